### rtl/core/ticks_to_calendar_fields_defines.svh
// Assertion helpers for the calendar conversion controller.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef TICKS_TO_CALENDAR_FIELDS_DEFINES_SVH
`define TICKS_TO_CALENDAR_FIELDS_DEFINES_SVH

// Same-cycle implication.
`define TCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcf_pkg.sv
`timescale 1ns / 1ps
package tcf_pkg;

  localparam int unsigned TicksW = 63;
  localparam int unsigned RemW   = 18;
  localparam int unsigned DaysW  = 24;
  // Dividend, quotient estimate, divisor and tick remainder widths.
  localparam int unsigned XW     = 49;
  localparam int unsigned QW     = 32;
  localparam int unsigned DvW    = 26;
  localparam int unsigned TrW    = 40;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_BACK, ST_FIX, ST_YEAR, ST_MONTH, ST_PUB
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_IN, OP_LOAD, OP_MUL, OP_BACK, OP_FIX, OP_STORE, OP_YEAR, OP_MONTH,
    OP_PUB
  } op_t;

  // Division passes, in the order they run.
  typedef enum logic [2:0] {
    DV_DAY, DV_HOUR, DV_MIN, DV_SEC, DV_MS, DV_WD, DV_CYC
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic fix;
  } sts_t;

  // Odd part of each divisor; the power of two is taken off by a shift.
  function automatic logic [DvW-1:0] divisor_of(input sel_t s);
    case (s)
      DV_DAY:  divisor_of = DvW'(52734375);
      DV_HOUR: divisor_of = DvW'(17578125);
      DV_MIN:  divisor_of = DvW'(1171875);
      DV_SEC:  divisor_of = DvW'(78125);
      DV_MS:   divisor_of = DvW'(625);
      DV_WD:   divisor_of = DvW'(7);
      DV_CYC:  divisor_of = DvW'(146097);
      default: divisor_of = DvW'(1);
    endcase
  endfunction

  // Reciprocals rounded down: 2^49 / d for the day pass, 2^32 / d for the rest.
  function automatic logic [QW-1:0] recip_of(input sel_t s);
    case (s)
      DV_DAY:  recip_of = QW'(10675199);
      DV_HOUR: recip_of = QW'(244);
      DV_MIN:  recip_of = QW'(3665);
      DV_SEC:  recip_of = QW'(54975);
      DV_MS:   recip_of = QW'(6871947);
      DV_WD:   recip_of = QW'(613566756);
      DV_CYC:  recip_of = QW'(29398);
      default: recip_of = QW'(0);
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    case (m)
      4'd1:    month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

endpackage

### rtl/core/tcf_ctrl.sv
`timescale 1ns / 1ps
`include "ticks_to_calendar_fields_defines.svh"
module tcf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tcf_pkg::sts_t sts,
  output tcf_pkg::cmd_t cmd
);
  import tcf_pkg::*;

  state_t          state_r, state_nxt;
  sel_t            sel_r, sel_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= DV_DAY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.sel       = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD_IN;
          cmd.sel   = DV_DAY;
          sel_nxt   = DV_DAY;
          state_nxt = ST_MUL;
        end
      end
      ST_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = ST_BACK;
      end
      ST_BACK: begin
        cmd.op    = OP_BACK;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        if (sts.fix) begin
          cmd.op = OP_FIX;
        end else begin
          cmd.op = OP_STORE;
          if (sel_r == DV_CYC) begin
            state_nxt = ST_YEAR;
          end else begin
            sel_nxt   = sel_t'(sel_r + 3'd1);
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_YEAR: begin
        if (sts.year_done) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.op = OP_YEAR;
        end
      end
      ST_MONTH: begin
        if (sts.month_done) begin
          state_nxt = ST_PUB;
        end else begin
          cmd.op = OP_MONTH;
        end
      end
      ST_PUB: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_PUB;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `TCF_ASSERT_NXT(a_pub_shows, cmd.op == OP_PUB, out_valid_r, "publish lost")
  `TCF_ASSERT_NXT(a_back_to_fix, state_r == ST_BACK, state_r == ST_FIX,
                  "remainder check skipped")
  `TCF_ASSERT_IMP(a_month_after_year, state_r == ST_MONTH, sts.year_done,
                  "month walk before year settled")
  `TCF_ASSERT_IMP(a_pub_no_clobber, cmd.op == OP_PUB, !(out_valid_r && out_stall),
                  "result overwritten while waiting")
endmodule

### rtl/core/tcf_dp.sv
`timescale 1ns / 1ps
module tcf_dp (
  input  logic                           clk,
  input  logic [tcf_pkg::TicksW-1:0]     in_ticks,
  input  tcf_pkg::cmd_t                  cmd,
  output tcf_pkg::sts_t                  sts,
  output logic [14:0]                    out_year,
  output logic [3:0]                     out_month,
  output logic [4:0]                     out_day,
  output logic [4:0]                     out_hour,
  output logic [5:0]                     out_minute,
  output logic [5:0]                     out_second,
  output logic [9:0]                     out_millisecond,
  output logic [2:0]                     out_weekday
);
  import tcf_pkg::*;

  logic [XW-1:0]     x_r;
  logic [QW-1:0]     q_r;
  logic [QW-1:0]     r_r;
  logic [TrW-1:0]    tr_r;
  logic [DaysW-1:0]  days_r;
  logic [RemW-1:0]   d_r;
  logic [14:0]       year_r;
  logic [8:0]        y1_r;
  logic [1:0]        m4_r;
  logic [6:0]        m100_r;
  logic [3:0]        mon_r;
  logic [9:0]        ms_r;
  logic [4:0]        hour_r;
  logic [5:0]        minute_r, second_r;
  logic [2:0]        wd_r;
  logic [14:0]       oyear_r;
  logic [3:0]        omon_r;
  logic [4:0]        oday_r, ohour_r;
  logic [5:0]        omin_r, osec_r;
  logic [9:0]        oms_r;
  logic [2:0]        owd_r;

  logic [QW-1:0]     xh;
  logic [DvW-1:0]    dvs;
  logic [QW-1:0]     rcp;
  logic [2*QW-1:0]   est_p;
  logic [QW+DvW-1:0] back_p;
  logic [XW-1:0]     diff;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic [DaysW-1:0]  days_p1;

  // Quotient estimate from the top 32 dividend bits (day pass) or the low 32; low by at most two.
  assign dvs     = divisor_of(cmd.sel);
  assign rcp     = recip_of(cmd.sel);
  assign xh      = (cmd.sel == DV_DAY) ? x_r[XW-1:XW-QW] : x_r[QW-1:0];
  assign est_p   = {{QW{1'b0}}, xh} * {{QW{1'b0}}, rcp};
  assign back_p  = {{DvW{1'b0}}, q_r} * {{QW{1'b0}}, dvs};
  assign diff    = x_r - back_p[XW-1:0];
  assign leap    = (m4_r == 2'd0) && ((m100_r != 7'd0) || (y1_r == 9'd400));
  assign ylen    = leap ? 9'd366 : 9'd365;
  assign mlen    = month_len(leap, mon_r);
  assign days_p1 = days_r + DaysW'(1);

  assign sts.year_done  = d_r < RemW'(ylen);
  assign sts.month_done = (mon_r == 4'd11) || (d_r < RemW'(mlen));
  assign sts.fix        = r_r >= QW'(dvs);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_IN: begin
        x_r  <= in_ticks[TicksW-1:14];
        tr_r <= {26'd0, in_ticks[13:0]};
      end
      // Hour to ms passes divide the tick remainder, its low zero bits shifted off; WD and CYC, days.
      OP_LOAD: begin
        case (cmd.sel)
          DV_HOUR: x_r <= XW'(tr_r[39:11]);
          DV_MIN:  x_r <= XW'(tr_r[35:9]);
          DV_SEC:  x_r <= XW'(tr_r[29:7]);
          DV_MS:   x_r <= XW'(tr_r[23:4]);
          DV_WD:   x_r <= XW'(days_p1);
          DV_CYC:  x_r <= XW'(days_r);
          default: x_r <= x_r;
        endcase
      end
      OP_MUL:  q_r <= est_p[2*QW-1:QW];
      OP_BACK: r_r <= diff[QW-1:0];
      OP_FIX: begin
        r_r <= r_r - QW'(dvs);
        q_r <= q_r + QW'(1);
      end
      OP_STORE: begin
        case (cmd.sel)
          DV_DAY: begin
            days_r <= q_r[DaysW-1:0];
            tr_r   <= {r_r[25:0], tr_r[13:0]};
          end
          DV_HOUR: begin
            hour_r <= q_r[4:0];
            tr_r   <= {4'd0, r_r[24:0], tr_r[10:0]};
          end
          DV_MIN: begin
            minute_r <= q_r[5:0];
            tr_r     <= {10'd0, r_r[20:0], tr_r[8:0]};
          end
          DV_SEC: begin
            second_r <= q_r[5:0];
            tr_r     <= {16'd0, r_r[16:0], tr_r[6:0]};
          end
          DV_MS:   ms_r <= q_r[9:0];
          DV_WD:   wd_r <= r_r[2:0];
          DV_CYC: begin
            year_r <= 15'd1601 + 15'(q_r[6:0]) * 15'd400;
            d_r    <= r_r[RemW-1:0];
            y1_r   <= 9'd1;
            m4_r   <= 2'd1;
            m100_r <= 7'd1;
            mon_r  <= 4'd0;
          end
          default: ms_r <= ms_r;
        endcase
      end
      OP_YEAR: begin
        d_r    <= d_r - RemW'(ylen);
        year_r <= year_r + 15'd1;
        y1_r   <= y1_r + 9'd1;
        m4_r   <= m4_r + 2'd1;
        m100_r <= (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
      end
      OP_MONTH: begin
        d_r   <= d_r - RemW'(mlen);
        mon_r <= mon_r + 4'd1;
      end
      OP_PUB: begin
        oyear_r <= year_r;
        omon_r  <= mon_r + 4'd1;
        oday_r  <= d_r[4:0] + 5'd1;
        ohour_r <= hour_r;
        omin_r  <= minute_r;
        osec_r  <= second_r;
        oms_r   <= ms_r;
        owd_r   <= wd_r;
      end
      default: x_r <= x_r;
    endcase
  end

  assign out_year        = oyear_r;
  assign out_month       = omon_r;
  assign out_day         = oday_r;
  assign out_hour        = ohour_r;
  assign out_minute      = omin_r;
  assign out_second      = osec_r;
  assign out_millisecond = oms_r;
  assign out_weekday     = owd_r;
endmodule

### rtl/core/ticks_to_calendar_fields.sv
`timescale 1ns / 1ps
// The time from input transfer to result valid grows with each correction of a quotient
// estimate, each year stepped inside the 400-year cycle (up to 399) and each month stepped
// (up to 11).
// One item at a time: the next transfer can be taken in the cycle after the result is
// published. A finished result waits in the output register while the next item runs.
// Reset (synchronous, active low) empties the controller and drops any pending result.
module ticks_to_calendar_fields (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tcf_pkg::TicksW-1:0] in_ticks,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [14:0]                out_year,
  output logic [3:0]                 out_month,
  output logic [4:0]                 out_day,
  output logic [4:0]                 out_hour,
  output logic [5:0]                 out_minute,
  output logic [5:0]                 out_second,
  output logic [9:0]                 out_millisecond,
  output logic [2:0]                 out_weekday
);
  import tcf_pkg::*;

  // The controller sequences seven divisions by constants (ticks to days, hours, minutes,
  // seconds and milliseconds, then weekday and 400-year cycles). Each one multiplies by a
  // stored reciprocal, multiplies back to form the remainder, and subtracts the divisor
  // while the remainder is still too large. Years and months are then walked one step per
  // cycle in the datapath.
  cmd_t cmd;
  sts_t sts;

  tcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath latches the ticks in the same cycle the input transfer completes.
  tcf_dp u_dp (
    .clk             (clk),
    .in_ticks        (in_ticks),
    .cmd             (cmd),
    .sts             (sts),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_millisecond (out_millisecond),
    .out_weekday     (out_weekday)
  );
endmodule
